/* rtl/core/cbor_item_skipper_defines.svh */
// assertion macros for the cbor item skipper
`ifndef CBOR_ITEM_SKIPPER_DEFINES_SVH
`define CBOR_ITEM_SKIPPER_DEFINES_SVH
`ifndef SYNTH
`define CIS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CIS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CIS_ASSERT(label, clk, rst_n, prop, msg)
`define CIS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/core/cis_pkg.sv */
// ----------------------------------------------------------------------------
// cis_pkg
// shared types and constants of the cbor item skipper
// ----------------------------------------------------------------------------
package cis_pkg;
	localparam int unsigned CisMaxDepth = 16;
	localparam logic [4:0] CisNestReset = 5'd16;

	typedef enum logic [1:0] {
		ST_OPEN = 2'd0,
		ST_DONE = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_HEAD    = 2'd0,
		PH_ARG     = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'd0,
		FSM_READ  = 3'd1,
		FSM_EXEC  = 3'd2,
		FSM_POP   = 3'd3,
		FSM_OUT   = 3'd4
	} fsm_t;

	typedef enum logic [3:0] {
		LK_ARR    = 4'd0,
		LK_MAPK   = 4'd1,
		LK_MAPV   = 4'd2,
		LK_IARR   = 4'd3,
		LK_IMAPK  = 4'd4,
		LK_IMAPV  = 4'd5,
		LK_IBYTES = 4'd6,
		LK_ITEXT  = 4'd7
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] nesting_depth;
	} out_beat_t;

	localparam logic [7:0] BreakByte = 8'hff;
endpackage

/* rtl/core/cis_ram.sv */
// ----------------------------------------------------------------------------
// cis_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module cis_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/cbor_item_skipper.sv */
// ----------------------------------------------------------------------------
// cbor_item_skipper
// finds the end of each top-level cbor item and checks that it is well formed
// ----------------------------------------------------------------------------
// One status beat comes out for every byte taken. A byte passes an idle and an
// exec state. In the idle state, the byte is taken and the top stack level is
// read from the level ram. In the exec state, the byte is decoded, the level is
// written back and the output register is loaded. The status beat is valid from
// the next cycle. Each extra container that the byte closes adds a read state, a
// re-read of the next level since the ram read is registered, and then a pop
// state for its update. The next byte is taken while a status beat waits in the
// output register. A byte that resolves while the previous beat still waits
// holds until that beat leaves. Level ram entries are only read below the stack
// depth, so the ram needs no clearing after reset.
`include "cbor_item_skipper_defines.svh"
module cbor_item_skipper
	import cis_pkg::*;
#(
	parameter int unsigned MaxDepth = CisMaxDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);
	localparam int unsigned AW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
	localparam int unsigned DW = $clog2(MaxDepth + 1);
	localparam int unsigned RW = 4 + 64;

	fsm_t fsm_q, fsm_d;
	phase_t phase_q;
	logic [2:0] major_q;
	logic [3:0] argleft_q;
	logic [63:0] argval_q;
	logic [63:0] payleft_q;
	logic tag_q;
	logic [DW-1:0] depth_q;
	logic [4:0] maxnest_q;
	in_beat_t byte_q;
	out_beat_t obuf_q;
	logic ovalid_q;

	// ram
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;
	kind_t         top_kind;
	logic [63:0]   top_count;

	cis_ram #(.Width(RW), .Depth(MaxDepth)) u_levels (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	assign top_kind  = kind_t'(rdata[RW-1 -: 4]);
	assign top_count = rdata[63:0];

	// output side can take a new beat
	logic adv;
	// decode state moves on this cycle
	logic step;
	assign adv = !ovalid_q || out_ready;

	// effective limit
	logic [DW-1:0] lim;
	always_comb begin
		if (maxnest_q == 5'd0) begin
			lim = DW'(1);
		end else if (32'(maxnest_q) > MaxDepth) begin
			lim = DW'(MaxDepth);
		end else begin
			lim = DW'(maxnest_q);
		end
	end

	// decode / execute results
	logic [1:0]    st;          // status when finished
	logic          fin;         // byte resolved
	logic          pop_more;    // continue item_done at level below
	phase_t        phase_n;
	logic [2:0]    major_n;
	logic [3:0]    argleft_n;
	logic [63:0]   argval_n, payleft_n;
	logic          tag_n;
	logic [DW-1:0] depth_n;

	logic [2:0] hmaj;
	logic [4:0] hinfo;
	logic       is_break;
	logic       have_top;

	// push, done and break helpers expressed inline
	always_comb begin
		logic        do_done;
		logic        do_push;
		logic        do_brk;
		kind_t       pkind;
		logic [63:0] pcount;
		logic [63:0] dec;
		logic [2:0]  hm;
		logic [63:0] hv;
		logic        hind;
		logic        do_headf;
		logic [63:0] av;

		do_done = 1'b0;
		do_push = 1'b0;
		do_brk  = 1'b0;
		pkind   = LK_ARR;
		pcount  = '0;
		dec     = top_count - 64'd1;
		hm      = '0;
		hv      = '0;
		hind    = 1'b0;
		do_headf = 1'b0;
		av      = {argval_q[55:0], byte_q.data_byte};

		st        = ST_OPEN;
		fin       = 1'b1;
		pop_more  = 1'b0;
		phase_n   = phase_q;
		major_n   = major_q;
		argleft_n = argleft_q;
		argval_n  = argval_q;
		payleft_n = payleft_q;
		tag_n     = tag_q;
		depth_n   = depth_q;
		we        = 1'b0;
		waddr     = AW'(depth_q - DW'(1));
		wdata     = rdata;

		hmaj     = byte_q.data_byte[7:5];
		hinfo    = byte_q.data_byte[4:0];
		is_break = (byte_q.data_byte == BreakByte);
		have_top = (depth_q != '0);

		if (fsm_q == FSM_POP) begin
			do_done = 1'b1;
		end else if (phase_q == PH_ARG) begin
			argval_n  = av;
			argleft_n = argleft_q - 4'd1;
			if (argleft_q == 4'd1) begin
				phase_n  = PH_HEAD;
				do_headf = 1'b1;
				hm = major_q;
				hv = av;
			end
		end else if (phase_q == PH_PAYLOAD) begin
			payleft_n = payleft_q - 64'd1;
			if (payleft_q == 64'd1) begin
				phase_n = PH_HEAD;
				do_done = 1'b1;
			end
		end else begin
			if (have_top && (top_kind == LK_IBYTES || top_kind == LK_ITEXT)
				&& is_break) begin
				do_brk = 1'b1;
			end else if (have_top && (top_kind == LK_IBYTES || top_kind == LK_ITEXT)
				&& ((hmaj != ((top_kind == LK_IBYTES) ? 3'd2 : 3'd3)) ||
				hinfo > 5'd27)) begin
				st = ST_ERR;
			end else if (hinfo == 5'd31) begin
				do_headf = 1'b1;
				hm = hmaj;
				hind = 1'b1;
			end else if (hinfo > 5'd27) begin
				st = ST_ERR;
			end else if (hinfo < 5'd24) begin
				do_headf = 1'b1;
				hm = hmaj;
				hv = 64'(hinfo);
			end else begin
				major_n   = hmaj;
				argval_n  = '0;
				argleft_n = 4'd1 << hinfo[1:0];
				phase_n   = PH_ARG;
			end
		end

		if (do_headf) begin
			if (hind) begin
				case (hm)
					3'd2: begin do_push = 1'b1; pkind = LK_IBYTES; end
					3'd3: begin do_push = 1'b1; pkind = LK_ITEXT; end
					3'd4: begin do_push = 1'b1; pkind = LK_IARR; end
					3'd5: begin do_push = 1'b1; pkind = LK_IMAPK; end
					3'd7: do_brk = 1'b1;
					default: st = ST_ERR;
				endcase
			end else begin
				case (hm)
					3'd2, 3'd3: begin
						if (hv == '0) begin
							do_done = 1'b1;
						end else begin
							payleft_n = hv;
							phase_n = PH_PAYLOAD;
						end
					end
					3'd4, 3'd5: begin
						if (hv == '0) begin
							do_done = 1'b1;
						end else begin
							do_push = 1'b1;
							pkind = (hm == 3'd4) ? LK_ARR : LK_MAPK;
							pcount = hv;
						end
					end
					3'd6: tag_n = 1'b1;
					default: do_done = 1'b1;
				endcase
			end
		end

		if (do_brk) begin
			if (tag_q || !have_top) begin
				st = ST_ERR;
			end else if (top_kind == LK_IARR || top_kind == LK_IMAPK ||
				top_kind == LK_IBYTES || top_kind == LK_ITEXT) begin
				depth_n  = depth_q - DW'(1);
				tag_n    = 1'b0;
				// item_done on the level below needs a fresh read
				if (depth_n == '0) begin
					st = ST_DONE;
				end else begin
					fin = 1'b0;
					pop_more = 1'b1;
				end
			end else begin
				st = ST_ERR;
			end
		end

		if (do_push) begin
			if (depth_q >= lim) begin
				st = ST_ERR;
			end else begin
				we      = 1'b1;
				waddr   = AW'(depth_q);
				wdata   = {pkind, pcount};
				depth_n = depth_q + DW'(1);
				tag_n   = 1'b0;
			end
		end

		if (do_done) begin
			tag_n = 1'b0;
			if (!have_top) begin
				st = ST_DONE;
			end else begin
				case (top_kind)
					LK_ARR, LK_MAPV: begin
						we    = 1'b1;
						wdata = {(top_kind == LK_MAPV) ? LK_MAPK : LK_ARR, dec};
						if (dec == '0) begin
							depth_n = depth_q - DW'(1);
							if (depth_n == '0) begin
								st = ST_DONE;
							end else begin
								fin = 1'b0;
								pop_more = 1'b1;
							end
						end
					end
					LK_MAPK: begin
						we = 1'b1;
						wdata = {LK_MAPV, top_count};
					end
					LK_IMAPK: begin
						we = 1'b1;
						wdata = {LK_IMAPV, top_count};
					end
					LK_IMAPV: begin
						we = 1'b1;
						wdata = {LK_IMAPK, top_count};
					end
					default: ;
				endcase
			end
		end

		if (st == ST_ERR) begin
			we = 1'b0;
			fin = 1'b1;
			pop_more = 1'b0;
		end

		// only a step that moves the state may touch the ram
		if (!((fsm_q == FSM_EXEC || fsm_q == FSM_POP) && (!fin || adv))) begin
			we = 1'b0;
		end
	end

	assign step = (fsm_q == FSM_EXEC || fsm_q == FSM_POP) && (!fin || adv);

	// read address: top of stack for next step
	always_comb begin
		if (step) begin
			raddr = AW'(depth_n - DW'(1));
		end else begin
			raddr = AW'(depth_q - DW'(1));
		end
	end

	logic take;
	assign in_ready  = (fsm_q == FSM_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			FSM_IDLE: if (take) fsm_d = FSM_EXEC;
			FSM_EXEC, FSM_POP: begin
				if (fin) begin
					// hold while the previous beat still waits
					if (adv) begin
						fsm_d = FSM_IDLE;
					end
				end else begin
					fsm_d = FSM_READ;
				end
			end
			FSM_READ: fsm_d = FSM_POP;
			default: fsm_d = FSM_IDLE;
		endcase
	end

	// final status with short buffer check
	logic [1:0] st_f;
	assign st_f = (st == ST_OPEN && byte_q.buffer_end) ? ST_ERR : st;

	logic exec_now;
	assign exec_now = step && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= FSM_IDLE;
			phase_q   <= PH_HEAD;
			major_q   <= '0;
			argleft_q <= '0;
			argval_q  <= '0;
			payleft_q <= '0;
			tag_q     <= 1'b0;
			depth_q   <= '0;
			maxnest_q <= CisNestReset;
			ovalid_q  <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (cfg_we) begin
				maxnest_q <= cfg_wdata;
			end
			if (exec_now) begin
				ovalid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (step) begin
				if (fin && st_f != ST_OPEN) begin
					phase_q   <= PH_HEAD;
					major_q   <= '0;
					argleft_q <= '0;
					argval_q  <= '0;
					payleft_q <= '0;
					tag_q     <= 1'b0;
					depth_q   <= '0;
				end else begin
					phase_q   <= phase_n;
					major_q   <= major_n;
					argleft_q <= argleft_n;
					argval_q  <= argval_n;
					payleft_q <= payleft_n;
					tag_q     <= tag_n;
					depth_q   <= depth_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= in_data;
		end
		if (exec_now) begin
			obuf_q.status        <= st_f;
			obuf_q.nesting_depth <= (st_f == ST_OPEN) ? 5'(depth_n) : 5'd0;
		end
	end

	`CIS_ASSERT(a_depth_lim, clk, arst_n, depth_q <= DW'(MaxDepth), "stack depth over limit")
	`CIS_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> fsm_q == FSM_IDLE, "ready outside idle")
	`CIS_ASSERT(a_out_zero, clk, arst_n,
		(out_valid && out_data.status != ST_OPEN) |-> out_data.nesting_depth == 5'd0,
		"depth not zero at item end")
	`CIS_ASSERT(a_status_ok, clk, arst_n, out_valid |-> out_data.status != 2'd3,
		"bad status code")
	`CIS_ASSERT(a_take_exec, clk, arst_n, take |=> fsm_q == FSM_EXEC, "byte taken but not run")
endmodule
